>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the idle-dim policy block; they report through
// $error and vanish in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IDP_ASSERT(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
		else $error("%m: check failed");
`define IDP_ASSERT_ALWAYS(lbl, clk_s, prop) \
	lbl: assert property (@(posedge clk_s) prop) \
		else $error("%m: check failed");
`else
`define IDP_ASSERT(lbl, clk_s, rstn_s, prop)
`define IDP_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif
`endif

>>> hw/rtl/idp_pkg.sv
// ----------------------------------------------------------------------------
// idp_pkg
// Shared codes, reset values and types of the backlight idle-dim controller.
// ----------------------------------------------------------------------------
package idp_pkg;

	localparam int TICK_COUNT_BITS_DEF = 17;

	localparam logic [1:0] MODE_ACTIVE = 2'd0;
	localparam logic [1:0] MODE_IDLE   = 2'd1;
	localparam logic [1:0] MODE_FORCE  = 2'd2;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_TOUCH = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam logic [2:0] REG_USER    = 3'd0;
	localparam logic [2:0] REG_FORCE   = 3'd1;
	localparam logic [2:0] REG_TIMEOUT = 3'd2;
	localparam logic [2:0] REG_DIM     = 3'd3;
	localparam logic [2:0] REG_CAP     = 3'd4;
	localparam logic [2:0] REG_FLOOR   = 3'd5;

	localparam logic [6:0]  LEVEL_MAX     = 7'd100;
	localparam logic [6:0]  USER_RST      = 7'd100;
	localparam logic [15:0] TIMEOUT_RST   = 16'd5000;
	localparam logic [6:0]  DIM_RST       = 7'd40;
	localparam logic [15:0] CAP_RST       = 16'd16;
	localparam logic [15:0] FLOOR_RST     = 16'd100;
	localparam logic [7:0]  NOT_APPLIED   = 8'd255;

	// x / 100 == (x * 5243) >> 19 for every x up to 100 * 100
	localparam logic [12:0] DIV100_MUL   = 13'd5243;
	localparam int          DIV100_SHIFT = 19;

	localparam logic [1:0] SETTLE_CYCLES = 2'd2;

	typedef struct packed {
		logic [6:0]  user;
		logic        force_on;
		logic [15:0] timeout;
		logic [15:0] cap;
		logic [15:0] floor_ms;
		logic [6:0]  dim_level;
	} cfg_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] applied;
	} core_stat_t;

	function automatic logic [6:0] sat100(input logic [6:0] v);
		sat100 = (v > LEVEL_MAX) ? LEVEL_MAX : v;
	endfunction

endpackage

>>> hw/rtl/idp_cfg.sv
// ----------------------------------------------------------------------------
// idp_cfg
// Configuration registers and the two-stage dimmed-level pipeline.
// ----------------------------------------------------------------------------
module idp_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output idp_pkg::cfg_t     cfg,
	output logic              busy
);

	logic [6:0]  user_q;
	logic        force_q;
	logic [15:0] timeout_q;
	logic [6:0]  dim_q;
	logic [15:0] cap_q;
	logic [15:0] floor_q;
	logic [13:0] prod_q;
	logic [6:0]  dim_lvl_q;
	logic [1:0]  settle_q;
	logic [26:0] scaled;
	logic [6:0]  quot;
	logic        wr;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_q    <= idp_pkg::USER_RST;
			force_q   <= 1'b0;
			timeout_q <= idp_pkg::TIMEOUT_RST;
			dim_q     <= idp_pkg::DIM_RST;
			cap_q     <= idp_pkg::CAP_RST;
			floor_q   <= idp_pkg::FLOOR_RST;
		end else if (wr) begin
			unique case (cfg_index)
				idp_pkg::REG_USER:    user_q    <= idp_pkg::sat100(cfg_data[6:0]);
				idp_pkg::REG_FORCE:   force_q   <= cfg_data[0];
				idp_pkg::REG_TIMEOUT: timeout_q <= cfg_data;
				idp_pkg::REG_DIM:     dim_q     <= idp_pkg::sat100(cfg_data[6:0]);
				idp_pkg::REG_CAP:     cap_q     <= cfg_data;
				idp_pkg::REG_FLOOR:   floor_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold off items until the dimmed level reflects the latest write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= idp_pkg::SETTLE_CYCLES;
		end else if (wr) begin
			settle_q <= idp_pkg::SETTLE_CYCLES;
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	assign scaled = {13'd0, prod_q} * {14'd0, idp_pkg::DIV100_MUL};
	assign quot   = scaled[idp_pkg::DIV100_SHIFT +: 7];

	always_ff @(posedge clk) begin
		prod_q    <= {7'd0, user_q} * {7'd0, dim_q};
		// floor at one for a nonzero user level
		dim_lvl_q <= (quot == 7'd0 && user_q != 7'd0) ? 7'd1 : quot;
	end

	assign busy = (settle_q != 2'd0);

	always_comb begin
		cfg.user      = user_q;
		cfg.force_on  = force_q;
		cfg.timeout   = timeout_q;
		cfg.cap       = cap_q;
		cfg.floor_ms  = floor_q;
		cfg.dim_level = dim_lvl_q;
	end

endmodule

>>> hw/rtl/idp_core.sv
// ----------------------------------------------------------------------------
// idp_core
// Mode, idle counter and applied-level state with the per-beat policy logic.
// ----------------------------------------------------------------------------
module idp_core #(
	parameter int TICK_COUNT_BITS = idp_pkg::TICK_COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic [1:0]           command,
	input  logic [15:0]          delay_request,
	input  idp_pkg::cfg_t        cfg,
	output logic [1:0]           mode,
	output logic                 write_valid,
	output logic [6:0]           brightness,
	output logic [15:0]          delay_out,
	output idp_pkg::core_stat_t  stat
);

	localparam int CW = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;

	logic [1:0]                 mode_q, mode_n;
	logic [TICK_COUNT_BITS-1:0] ticks_q, ticks_n, ticks_inc;
	logic [7:0]                 applied_q;
	logic                       act_now, act_n, lvl_chg, apply;

	assign ticks_inc = (&ticks_q) ? ticks_q : ticks_q + TICK_COUNT_BITS'(1);
	assign act_now   = cfg.force_on || mode_q != idp_pkg::MODE_IDLE;

	always_comb begin
		ticks_n   = ticks_q;
		mode_n    = mode_q;
		apply     = 1'b0;
		delay_out = 16'd0;
		unique case (command)
			idp_pkg::CMD_TICK: begin
				ticks_n = ticks_inc;
				priority if (cfg.force_on)
					mode_n = idp_pkg::MODE_FORCE;
				else if (CW'(ticks_inc) <= CW'(cfg.timeout))
					mode_n = idp_pkg::MODE_ACTIVE;
				else
					mode_n = idp_pkg::MODE_IDLE;
				apply = 1'b1;
			end
			idp_pkg::CMD_TOUCH: begin
				ticks_n = '0;
				if (!cfg.force_on) begin
					mode_n = idp_pkg::MODE_ACTIVE;
					apply  = 1'b1;
				end
			end
			idp_pkg::CMD_QUERY: begin
				if (act_now)
					delay_out = (delay_request > cfg.cap) ? cfg.cap : delay_request;
				else
					delay_out = (delay_request < cfg.floor_ms) ? cfg.floor_ms
						: delay_request;
			end
			default: ;
		endcase
	end

	assign act_n       = cfg.force_on || mode_n != idp_pkg::MODE_IDLE;
	assign brightness  = act_n ? cfg.user : cfg.dim_level;
	assign lvl_chg     = {1'b0, brightness} != applied_q;
	assign write_valid = apply && lvl_chg;
	assign mode        = mode_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= idp_pkg::MODE_ACTIVE;
			ticks_q   <= '0;
			applied_q <= idp_pkg::NOT_APPLIED;
		end else if (adv) begin
			mode_q  <= mode_n;
			ticks_q <= ticks_n;
			if (write_valid)
				applied_q <= {1'b0, brightness};
		end
	end

	assign stat.mode    = mode_q;
	assign stat.applied = applied_q;

endmodule

>>> hw/rtl/display_idle_dim_policy_unit.sv
// ----------------------------------------------------------------------------
// display_idle_dim_policy_unit
// Backlight idle-dim controller: tick, touch and delay-query beats in,
// mode, panel write flag, brightness and adjusted delay out.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the output is not stalled and no settle
// is pending. A beat lands in the input register, is evaluated against the
// mode, idle counter and applied level, and its result is registered in the
// output register; the output register lets a new beat enter while a result
// waits. The dimmed level (user * dim / 100) comes from a two-stage multiply
// pipeline behind the configuration registers, so after reset and after every
// configuration write the input side stays not-ready until the pipeline settles.
`include "assert_macros.svh"

module display_idle_dim_policy_unit #(
	parameter int TICK_COUNT_BITS = idp_pkg::TICK_COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [15:0] delay_request,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  mode,
	output logic        write_valid,
	output logic [6:0]  brightness,
	output logic [15:0] delay_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	idp_pkg::cfg_t       cfg;
	idp_pkg::core_stat_t stat;
	logic                busy;
	logic                v_s1, v_s2, adv, accept;
	logic [1:0]          cmd_s1;
	logic [15:0]         req_s1;
	logic [1:0]          mode_c;
	logic                wr_c;
	logic [6:0]          bri_c;
	logic [15:0]         dly_c;
	logic [1:0]          mode_s2;
	logic                wr_s2;
	logic [6:0]          bri_s2;
	logic [15:0]         dly_s2;
	logic                wr_pend;

	idp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.busy      (busy)
	);

	assign adv      = v_s1 && (!v_s2 || out_ready);
	assign in_ready = !busy && (!v_s1 || adv);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= command;
			req_s1 <= delay_request;
		end
	end

	idp_core #(
		.TICK_COUNT_BITS (TICK_COUNT_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.command       (cmd_s1),
		.delay_request (req_s1),
		.cfg           (cfg),
		.mode          (mode_c),
		.write_valid   (wr_c),
		.brightness    (bri_c),
		.delay_out     (dly_c),
		.stat          (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= 1'b1;
		end else if (out_ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2 <= mode_c;
			wr_s2   <= wr_c;
			bri_s2  <= bri_c;
			dly_s2  <= dly_c;
		end
	end

	assign out_valid   = v_s2;
	assign mode        = mode_s2;
	assign write_valid = wr_s2;
	assign brightness  = bri_s2;
	assign delay_out   = dly_s2;

	assign wr_pend = v_s2 && wr_s2;

	`IDP_ASSERT_ALWAYS(a_settle_blocks_input, clk, busy |-> !in_ready)
	`IDP_ASSERT(a_write_matches_applied, clk, arst_n, wr_pend |-> ({1'b0, bri_s2} == stat.applied))
	`IDP_ASSERT(a_state_moves_on_adv, clk, arst_n, !adv |=> $stable(stat))

endmodule

>>> tb/display_idle_dim_policy_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// display_idle_dim_policy_unit_tb
// Self-checking bench for the backlight idle-dim controller. Tick, touch and
// delay-query beats are driven through a valid/ready port. A scoreboard model
// of mode, idle counter and applied level predicts each result beat. Both
// ends idle and stall at random. Register settings change between phases.
// ----------------------------------------------------------------------------
module display_idle_dim_policy_unit_tb;

	localparam int          TICK_BITS   = idp_pkg::TICK_COUNT_BITS_DEF;
	localparam logic [1:0]  CMD_SPARE   = 2'd3;
	localparam logic [2:0]  REG_SPARE_LO = 3'd6;
	localparam logic [2:0]  REG_SPARE_HI = 3'd7;
	localparam int          SETTLE_WAIT = 4;
	localparam int          HOLD_CYCLES = 200;
	localparam int          PHASE_BEATS = 175;
	localparam int          CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] req;
	} policy_cmd_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic        panel_write;
		logic [6:0]  level;
		logic [15:0] delay;
	} policy_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  command = idp_pkg::CMD_TICK;
	logic [15:0] delay_request = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  mode;
	logic        write_valid;
	logic [6:0]  brightness;
	logic [15:0] delay_out;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = idp_pkg::REG_USER;
	logic [15:0] cfg_data = '0;

	// scoreboard copy of the registers and state
	logic [6:0]           c_user;
	logic                 c_force;
	logic [15:0]          c_timeout;
	logic [6:0]           c_dim;
	logic [15:0]          c_cap;
	logic [15:0]          c_floor;
	logic [1:0]           pm_mode;
	logic [TICK_BITS-1:0] pm_ticks;
	logic [7:0]           pm_applied;

	policy_cmd_t    policy_cmds_q[$];
	policy_result_t policy_results_q[$];
	policy_cmd_t    next_beat;
	policy_result_t want_beat;
	policy_result_t got_beat;

	int gap_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_served = 0;
	int hold_left = 0;
	int fails = 0;
	int cycle_count = 0;

	display_idle_dim_policy_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.delay_request (delay_request),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.mode          (mode),
		.write_valid   (write_valid),
		.brightness    (brightness),
		.delay_out     (delay_out),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic logic panel_awake();
		return c_force || pm_mode == idp_pkg::MODE_ACTIVE
			|| pm_mode == idp_pkg::MODE_FORCE;
	endfunction

	function automatic logic [6:0] level_now();
		int scaled;
		if (panel_awake())
			return c_user;
		scaled = int'(c_user) * int'(c_dim) / 100;
		if (c_user != 0 && scaled == 0)
			return 7'd1;
		return scaled[6:0];
	endfunction

	function automatic logic apply_level();
		logic [7:0] target;
		target = {1'b0, level_now()};
		if (target == pm_applied)
			return 1'b0;
		pm_applied = target;
		return 1'b1;
	endfunction

	function automatic policy_result_t step_policy(input logic [1:0] cmd,
			input logic [15:0] req);
		policy_result_t res;
		res = '0;
		case (cmd)
			idp_pkg::CMD_TICK: begin
				if (pm_ticks != '1)
					pm_ticks = pm_ticks + 1'b1;
				if (c_force)
					pm_mode = idp_pkg::MODE_FORCE;
				else if (pm_ticks <= c_timeout)
					pm_mode = idp_pkg::MODE_ACTIVE;
				else
					pm_mode = idp_pkg::MODE_IDLE;
				res.panel_write = apply_level();
			end
			idp_pkg::CMD_TOUCH: begin
				pm_ticks = '0;
				if (!c_force) begin
					pm_mode = idp_pkg::MODE_ACTIVE;
					res.panel_write = apply_level();
				end
			end
			idp_pkg::CMD_QUERY: begin
				if (panel_awake())
					res.delay = (req > c_cap) ? c_cap : req;
				else
					res.delay = (req < c_floor) ? c_floor : req;
			end
			default: ;
		endcase
		res.mode = pm_mode;
		res.level = level_now();
		return res;
	endfunction

	function automatic void apply_setting(input logic [2:0] idx, input logic [15:0] data);
		case (idx)
			idp_pkg::REG_USER:    c_user = (data[6:0] > 7'd100) ? 7'd100 : data[6:0];
			idp_pkg::REG_FORCE:   c_force = data[0];
			idp_pkg::REG_TIMEOUT: c_timeout = data;
			idp_pkg::REG_DIM:     c_dim = (data[6:0] > 7'd100) ? 7'd100 : data[6:0];
			idp_pkg::REG_CAP:     c_cap = data;
			idp_pkg::REG_FLOOR:   c_floor = data;
			default: ;
		endcase
	endfunction

	function automatic void check_beat(input policy_result_t want, input policy_result_t got);
		if (got.mode !== want.mode) begin
			$error("mode: expected %0d, got %0d", want.mode, got.mode);
			fails++;
		end
		if (got.panel_write !== want.panel_write) begin
			$error("write_valid: expected %0d, got %0d", want.panel_write, got.panel_write);
			fails++;
		end
		if (got.level !== want.level) begin
			$error("brightness: expected %0d, got %0d", want.level, got.level);
			fails++;
		end
		if (got.delay !== want.delay) begin
			$error("delay_out: expected %0d, got %0d", want.delay, got.delay);
			fails++;
		end
	endfunction

	task automatic queue_beat(input logic [1:0] cmd, input logic [15:0] req);
		policy_cmds_q.push_back('{cmd: cmd, req: req});
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_setting(idx, data);
		cfg_valid <= 1'b0;
	endtask

	// wait until every beat is sent and every result is back
	task automatic drain();
		@(posedge clk);
		while (policy_cmds_q.size() != 0 || in_valid || policy_results_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= idp_pkg::CMD_TICK;
			delay_request <= '0;
		end else begin
			if (in_valid && in_ready)
				policy_results_q.push_back(step_policy(command, delay_request));
			// hold the beat until it is taken
			if (!in_valid || in_ready) begin
				if (policy_cmds_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
					next_beat = policy_cmds_q.pop_front();
					in_valid <= 1'b1;
					command <= next_beat.cmd;
					delay_request <= next_beat.req;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got_beat = '{mode: mode, panel_write: write_valid, level: brightness,
					delay: delay_out};
				if (policy_results_q.size() == 0) begin
					$error("result beat with nothing pending: mode %0d brightness %0d",
						mode, brightness);
					fails++;
				end else begin
					want_beat = policy_results_q.pop_front();
					check_beat(want_beat, got_beat);
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// long receiver hold-off, armed by the stimulus process
	always @(posedge clk) begin
		if (hold_served != hold_req) begin
			hold_served <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [15:0] vals[6];
		int          r;
		logic [15:0] req;
		logic [1:0]  cmd;

		c_user = 7'd100;
		c_force = 1'b0;
		c_timeout = 16'd5000;
		c_dim = 7'd40;
		c_cap = 16'd16;
		c_floor = 16'd100;
		pm_mode = idp_pkg::MODE_ACTIVE;
		pm_ticks = '0;
		pm_applied = 8'd255;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: first tick applies full level, queries get capped
		queue_beat(idp_pkg::CMD_TICK, 16'd0);
		queue_beat(idp_pkg::CMD_TOUCH, 16'hFFFF);
		queue_beat(idp_pkg::CMD_QUERY, 16'd0);
		queue_beat(idp_pkg::CMD_QUERY, 16'hFFFF);
		queue_beat(idp_pkg::CMD_QUERY, 16'd16);
		queue_beat(idp_pkg::CMD_QUERY, 16'd17);
		queue_beat(CMD_SPARE, 16'hFFFF);
		drain();

		// short timeout: cross into idle dim and wake up again
		cfg_write(idp_pkg::REG_TIMEOUT, 16'd2);
		@(negedge clk);
		repeat (4) queue_beat(idp_pkg::CMD_TICK, 16'd0);
		queue_beat(idp_pkg::CMD_QUERY, 16'd0);
		queue_beat(idp_pkg::CMD_QUERY, 16'hFFFF);
		queue_beat(CMD_SPARE, 16'd0);
		queue_beat(idp_pkg::CMD_TOUCH, 16'd0);
		queue_beat(idp_pkg::CMD_TICK, 16'd0);
		drain();

		// forced mode ignores touch; clearing force keeps forced mode until a tick
		cfg_write(idp_pkg::REG_FORCE, 16'd1);
		@(negedge clk);
		queue_beat(idp_pkg::CMD_TICK, 16'd0);
		queue_beat(idp_pkg::CMD_TOUCH, 16'd0);
		queue_beat(idp_pkg::CMD_QUERY, 16'hFFFF);
		drain();
		cfg_write(idp_pkg::REG_FORCE, 16'd0);
		@(negedge clk);
		queue_beat(idp_pkg::CMD_QUERY, 16'd5);
		queue_beat(CMD_SPARE, 16'd0);
		queue_beat(idp_pkg::CMD_TICK, 16'd0);
		drain();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: vals = '{16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF};
				1: vals = '{16'd0, 16'd0, 16'd3, 16'hFFFF, 16'hFFFF, 16'd0};
				2: vals = '{16'd1, 16'd0, 16'd1, 16'd1, 16'($urandom), 16'($urandom)};
				3: vals = '{16'($urandom), 16'hFFFF, 16'hFFFF, 16'($urandom),
					16'($urandom), 16'($urandom)};
				4: vals = '{16'($urandom), 16'hFFFE, 16'($urandom_range(0, 8)),
					16'($urandom), 16'($urandom), 16'($urandom)};
				default: vals = '{16'($urandom), 16'($urandom_range(0, 3) == 0),
					16'($urandom_range(0, 12)), 16'($urandom), 16'($urandom),
					16'($urandom)};
			endcase
			for (int i = 0; i < 6; i++)
				cfg_write(3'(i), vals[i]);
			cfg_write(REG_SPARE_LO, 16'($urandom));
			cfg_write(REG_SPARE_HI, 16'($urandom));

			@(negedge clk);
			case (p % 4)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 79; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 79; end
				default: begin gap_pct = 30; stall_pct = 30; end
			endcase

			// mostly ticks so idle dim is reached, with touches and queries mixed in
			for (int n = 0; n < PHASE_BEATS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 50)
					cmd = idp_pkg::CMD_TICK;
				else if (r < 62)
					cmd = idp_pkg::CMD_TOUCH;
				else if (r < 95)
					cmd = idp_pkg::CMD_QUERY;
				else
					cmd = CMD_SPARE;
				case ($urandom_range(0, 9))
					0: req = 16'd0;
					1: req = 16'hFFFF;
					2: req = c_cap;
					3: req = c_cap + 16'd1;
					4: req = c_floor;
					5: req = c_floor - 16'd1;
					default: req = 16'($urandom);
				endcase
				queue_beat(cmd, req);
			end
			if (p == 4)
				hold_req = hold_req + 1;
			drain();
		end

		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
